// File: hw/rtl/matrix3_inverse_core_macros.svh
// ----------------------------------------------------------------------------
// matrix3_inverse_core_macros : assertion macros
// Concurrent assertion wrappers, empty when built for synthesis.
// ----------------------------------------------------------------------------
`ifndef MATRIX3_INVERSE_CORE_MACROS_SVH
`define MATRIX3_INVERSE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define MI3_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("implication check failed");
`define MI3_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("next-cycle check failed");
`else
`define MI3_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define MI3_ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

// File: hw/rtl/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg : 3x3 matrix inverse package
// Formats, widths and the cofactor index table.
// ----------------------------------------------------------------------------
package mi3_pkg;

    localparam int ELEM_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int N_ELEM     = 9;

    localparam int W      = ELEM_WIDTH;
    localparam int PW     = 2 * W;
    localparam int AW     = 2 * W + 1;
    localparam int DW     = 3 * W + 3;
    localparam int CW     = 4 * W + 4;
    localparam int NSHIFT = 2 * FRAC_BITS + 1;
    localparam int NSTAGE = W + 7;
    localparam int DATA_W = N_ELEM * W;

    typedef logic signed [W-1:0]  t_elem;
    typedef logic signed [PW-1:0] t_prod;
    typedef logic signed [AW-1:0] t_adj;
    typedef logic signed [2*W:0]  t_part;
    typedef logic signed [DW-1:0] t_det;
    typedef logic        [CW-1:0] t_wide;
    typedef logic        [W-1:0]  t_quo;

    localparam logic [3:0] ADJ_IDX [N_ELEM][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
    };

endpackage

// File: hw/rtl/matrix3_inverse_core.sv
// ----------------------------------------------------------------------------
// matrix3_inverse_core : pipelined 3x3 fixed-point matrix inverse
// Adjugate, determinant by first-row expansion, rounded exact quotient per
// entry through a bit-per-stage restoring divider, saturation and singular flag.
//
//   port group   direction   tdata                       tuser
//   i_s_*        in          a00..a22, 32 bits each      -
//   o_m_*        out         b00..b22, 32 bits each      singular, saturated
//
// One word accepted per cycle while the output is not stalled.
// Reset (synchronous, active low) clears the stage valid bits only.
// A stall at the output freezes the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "matrix3_inverse_core_macros.svh"

module matrix3_inverse_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [mi3_pkg::DATA_W-1:0]  i_s_tdata,   // a00,a01,a02,a10,a11,a12,a20,a21,a22
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [mi3_pkg::DATA_W-1:0]  o_m_tdata,   // b00,b01,b02,b10,b11,b12,b20,b21,b22
    output logic [1:0]                  o_m_tuser    // singular, saturated
);
    import mi3_pkg::*;

    logic              en;
    logic [NSTAGE-1:0] r_v;

    t_elem r_a    [N_ELEM];
    t_prod r_p    [2*N_ELEM];
    t_elem r_a1   [3];
    t_adj  r_adj2 [N_ELEM];
    t_elem r_a2   [3];
    t_adj  r_adj3 [N_ELEM];
    t_part r_plo  [3];
    t_part r_phi  [3];
    t_adj  r_adj4 [N_ELEM];
    t_det  r_det;

    t_wide             r_drem  [W+1][N_ELEM];
    t_quo              r_dq    [W+1][N_ELEM];
    t_wide             r_dden  [W+1];
    logic [N_ELEM-1:0] r_dneg  [W+1];
    logic [N_ELEM-1:0] r_dbig  [W+1];
    logic [W:0]        r_dzero;

    t_wide             n_drem  [W][N_ELEM];
    t_quo              n_dq    [W][N_ELEM];

    t_elem r_out [N_ELEM];
    logic  r_sing;
    logic  r_sat;

    logic              c_dneg;
    t_det              c_dmag;
    t_wide             c_den2;
    t_wide             c_num   [N_ELEM];
    logic [N_ELEM-1:0] c_neg;
    t_adj              c_nmag;

    t_elem             n_out   [N_ELEM];
    logic              n_sat;
    t_quo              c_lim;
    t_quo              c_lo;
    logic              c_ksat;
    t_wide             c_t;

    assign en         = !r_v[NSTAGE-1] || i_m_tready;
    assign o_s_tready = en;
    assign o_m_tvalid = r_v[NSTAGE-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NSTAGE-2:0], i_s_tvalid};
        end
    end

    always_comb begin
        c_dneg = r_det[DW-1];
        c_dmag = c_dneg ? -r_det : r_det;
        c_den2 = t_wide'(c_dmag) << 1;
        for (int k = 0; k < N_ELEM; k++) begin
            c_neg[k] = r_adj4[k][AW-1] ^ c_dneg;
            c_nmag   = r_adj4[k][AW-1] ? -r_adj4[k] : r_adj4[k];
            c_num[k] = (t_wide'(c_nmag) << NSHIFT) + t_wide'(c_dmag);
        end
    end

    always_comb begin
        c_t = '0;
        for (int d = 0; d < W; d++) begin
            c_t = r_dden[d] << (W - 1 - d);
            for (int k = 0; k < N_ELEM; k++) begin
                if (r_drem[d][k] >= c_t) begin
                    n_drem[d][k] = r_drem[d][k] - c_t;
                    n_dq[d][k]   = r_dq[d][k] | (t_quo'(1) << (W - 1 - d));
                end else begin
                    n_drem[d][k] = r_drem[d][k];
                    n_dq[d][k]   = r_dq[d][k];
                end
            end
        end
    end

    always_comb begin
        n_sat  = 1'b0;
        c_lim  = '0;
        c_lo   = '0;
        c_ksat = 1'b0;
        for (int k = 0; k < N_ELEM; k++) begin
            c_lim  = r_dneg[W][k] ? (t_quo'(1) << (W - 1)) : ((t_quo'(1) << (W - 1)) - 1'b1);
            c_ksat = r_dbig[W][k] || (r_dq[W][k] > c_lim);
            c_lo   = c_ksat ? c_lim : r_dq[W][k];
            n_out[k] = r_dneg[W][k] ? t_elem'(-c_lo) : t_elem'(c_lo);
            if (r_dzero[W]) begin
                n_out[k] = '0;
            end else if (c_ksat) begin
                n_sat = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < N_ELEM; k++) begin
                r_a[k] <= i_s_tdata[k*W +: W];
            end
            for (int k = 0; k < N_ELEM; k++) begin
                r_p[2*k]   <= r_a[ADJ_IDX[k][0]] * r_a[ADJ_IDX[k][1]];
                r_p[2*k+1] <= r_a[ADJ_IDX[k][2]] * r_a[ADJ_IDX[k][3]];
            end
            for (int j = 0; j < 3; j++) begin
                r_a1[j] <= r_a[j];
                r_a2[j] <= r_a1[j];
            end
            for (int k = 0; k < N_ELEM; k++) begin
                r_adj2[k] <= t_adj'(r_p[2*k]) - t_adj'(r_p[2*k+1]);
                r_adj3[k] <= r_adj2[k];
                r_adj4[k] <= r_adj3[k];
            end
            for (int j = 0; j < 3; j++) begin
                r_plo[j] <= $signed({1'b0, r_adj2[3*j][W-1:0]}) * r_a2[j];
                r_phi[j] <= $signed(r_adj2[3*j][AW-1:W]) * r_a2[j];
            end
            r_det <= (t_det'(r_phi[0]) << W) + t_det'(r_plo[0])
                   + (t_det'(r_phi[1]) << W) + t_det'(r_plo[1])
                   + (t_det'(r_phi[2]) << W) + t_det'(r_plo[2]);
            r_dden[0]  <= c_den2;
            r_dneg[0]  <= c_neg;
            r_dzero[0] <= (r_det == '0);
            for (int k = 0; k < N_ELEM; k++) begin
                r_drem[0][k] <= c_num[k];
                r_dq[0][k]   <= '0;
                r_dbig[0][k] <= (c_num[k] >= (c_den2 << W));
            end
            for (int d = 0; d < W; d++) begin
                r_dden[d+1]  <= r_dden[d];
                r_dneg[d+1]  <= r_dneg[d];
                r_dbig[d+1]  <= r_dbig[d];
                r_dzero[d+1] <= r_dzero[d];
                for (int k = 0; k < N_ELEM; k++) begin
                    r_drem[d+1][k] <= n_drem[d][k];
                    r_dq[d+1][k]   <= n_dq[d][k];
                end
            end
            r_out  <= n_out;
            r_sing <= r_dzero[W];
            r_sat  <= n_sat;
        end
    end

    always_comb begin
        for (int k = 0; k < N_ELEM; k++) begin
            o_m_tdata[k*W +: W] = r_out[k];
        end
    end
    assign o_m_tuser = {r_sat, r_sing};

    `MI3_ASSERT_IMP(a_sing_zero, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[0], (o_m_tdata == '0) && !o_m_tuser[1])
    `MI3_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_s_tvalid && o_s_tready, r_v[0])
    `MI3_ASSERT_NEXT(a_stall_freezes, i_clk, i_rst_n, !en, $stable(r_v))

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb : regression bench for matrix3_inverse_core
// Drives 3x3 Q16.16 matrices through the stream input with random gaps and
// receiver stalls, predicts each inverse with exact wide arithmetic and
// checks every output word in order against the prediction.
// ----------------------------------------------------------------------------
import mi3_pkg::*;

typedef struct packed {
    logic [DATA_W-1:0] tdata;
    logic [1:0]        tuser;
} t_inv_word;

class inverse_board;
    t_inv_word pending[$];
    int        mismatches;
    int        checked;
    int        singular_seen;
    int        saturated_seen;

    function automatic t_inv_word compute_inverse(logic [DATA_W-1:0] m);
        logic signed [255:0] a [9];
        logic signed [255:0] adj [9];
        logic signed [255:0] det, nmag, dmag, num, q;
        logic [255:0]        limit;
        logic                neg, sat;
        t_inv_word           r;
        for (int k = 0; k < 9; k++)
            a[k] = {{(256-W){m[k*W+W-1]}}, m[k*W +: W]};
        for (int k = 0; k < 9; k++)
            adj[k] = a[ADJ_IDX[k][0]] * a[ADJ_IDX[k][1]]
                   - a[ADJ_IDX[k][2]] * a[ADJ_IDX[k][3]];
        det = a[0] * adj[0] + a[1] * adj[3] + a[2] * adj[6];
        r = '0;
        sat = 1'b0;
        if (det == 0) begin
            r.tuser = 2'b01;
            return r;
        end
        dmag = det < 0 ? -det : det;
        for (int k = 0; k < 9; k++) begin
            nmag = adj[k] < 0 ? -adj[k] : adj[k];
            neg  = (adj[k] < 0) != (det < 0);
            num  = (nmag <<< (2 * FRAC_BITS + 1)) + dmag;
            q    = num / (dmag <<< 1);
            limit = neg ? (256'd1 << (W - 1)) : ((256'd1 << (W - 1)) - 1);
            if ($unsigned(q) > limit) begin
                q = limit;
                sat = 1'b1;
            end
            if (neg) q = -q;
            r.tdata[k*W +: W] = q[W-1:0];
        end
        r.tuser = {sat, 1'b0};
        return r;
    endfunction

    function void note_matrix(logic [DATA_W-1:0] m);
        pending.push_back(compute_inverse(m));
    endfunction

    function void check_inverse(logic [DATA_W-1:0] d, logic [1:0] u);
        t_inv_word e;
        checked++;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected output word %h", d);
            return;
        end
        e = pending.pop_front();
        if (u[0]) singular_seen++;
        if (u[1]) saturated_seen++;
        for (int k = 0; k < 9; k++)
            if (d[k*W +: W] !== e.tdata[k*W +: W]) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("word %0d b%0d%0d: expected %h got %h", checked, k / 3,
                             k % 3, e.tdata[k*W +: W], d[k*W +: W]);
            end
        for (int f = 0; f < 2; f++)
            if (u[f] !== e.tuser[f]) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("word %0d %s: expected %b got %b", checked,
                             f ? "saturated" : "singular", e.tuser[f], u[f]);
            end
    endfunction
endclass

module tb;
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [DATA_W-1:0] i_s_tdata = '0;
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [DATA_W-1:0] o_m_tdata;
    logic [1:0]        o_m_tuser;

    inverse_board board = new();
    logic         hold_off = 1'b0;
    logic         sending_done = 1'b0;
    int           sent = 0;

    matrix3_inverse_core DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int gap_len();
        int p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [W-1:0] rand_elem();
        case ($urandom_range(0, 9))
            0: return {1'b0, {(W-1){1'b1}}};
            1: return {1'b1, {(W-1){1'b0}}};
            2: return '0;
            3: return W'($signed($urandom_range(0, 8)) - 4) << FRAC_BITS;
            4: return W'($signed($urandom_range(0, 64)) - 32);
            5: return {{(W-20){$urandom_range(0, 1) == 1}}, 20'($urandom)};
            default: return W'($urandom);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_matrix();
        logic [DATA_W-1:0] m;
        int kind = $urandom_range(0, 9);
        for (int k = 0; k < 9; k++) m[k*W +: W] = rand_elem();
        if (kind == 0) m[3*W +: 3*W] = m[0 +: 3*W];
        else if (kind == 1) m[6*W +: 3*W] = '0;
        else if (kind == 2)
            for (int k = 0; k < 9; k++)
                m[k*W +: W] = (k % 4 == 0) ? rand_elem() : W'($urandom_range(0, 3));
        return m;
    endfunction

    function automatic logic [DATA_W-1:0] diag(logic [W-1:0] x, logic [W-1:0] y,
                                               logic [W-1:0] z);
        return {z, W'(0), W'(0), W'(0), y, W'(0), W'(0), W'(0), x};
    endfunction

    task automatic send_matrix(logic [DATA_W-1:0] m);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= m;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        board.note_matrix(m);
        sent++;
        for (int g = gap_len(); g > 0; g--) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    initial begin
        logic [DATA_W-1:0] dir [$];
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        dir.push_back(diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        dir.push_back(diag(32'h0002_0000, 32'hFFFC_0000, 32'h0000_8000));
        dir.push_back('0);
        dir.push_back({DATA_W{1'b1}});
        dir.push_back(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        dir.push_back(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        dir.push_back(diag(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
        dir.push_back(diag(32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000));
        dir.push_back(diag(32'h0000_0003, 32'h0001_0000, 32'h0001_0000));
        dir.push_back(diag(32'hFFFF_FFFD, 32'h0001_0000, 32'h0001_0000));
        dir.push_back({DATA_W/32{32'h5555_AAAA}});
        dir.push_back({DATA_W/32{32'hAAAA_5555}});
        dir.push_back({32'h0009_0000, 32'h0008_0000, 32'h0007_0000, 32'h0006_0000,
                       32'h0005_0000, 32'h0004_0000, 32'h0003_0000, 32'h0002_0000,
                       32'h0001_0000});
        dir.push_back({32'h0001_0000, 32'h0, 32'h0, 32'h0002_0000, 32'h0001_0000,
                       32'h0, 32'h0003_0000, 32'h0004_0000, 32'h0001_0000});
        foreach (dir[i]) send_matrix(dir[i]);
        for (int n = 0; n < 1400; n++) begin
            if (n == 300) hold_off = 1'b1;
            send_matrix(rand_matrix());
        end
        i_s_tvalid <= 1'b0;
        sending_done = 1'b1;
    end

    initial begin
        @(posedge hold_off);
        repeat (400) @(posedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        int g;
        @(posedge i_rst_n);
        forever begin
            g = gap_len();
            if (hold_off || g > 0) begin
                i_m_tready <= 1'b0;
                @(posedge i_clk);
                while (hold_off) @(posedge i_clk);
                for (int c = 1; c < g; c++) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            if (o_m_tvalid) board.check_inverse(o_m_tdata, o_m_tuser);
        end
    end

    initial begin
        wait (sending_done);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (NSTAGE + 20) @(posedge i_clk);
        $display("%0d matrices sent, %0d inverses checked", sent, board.checked);
        $display("%0d singular and %0d saturated results among them",
                 board.singular_seen, board.saturated_seen);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("matrix3_inverse_core regression: pass");
        else
            $display("matrix3_inverse_core regression: fail");
        $finish;
    end

    initial begin
        #2000000;
        $display("matrix3_inverse_core regression: fail");
        $finish;
    end
endmodule
